### src/abrf_pkg.sv
// shared types, access codes and mode decode for the banked register file
package abrf_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned MODE_W = 5;
	localparam int unsigned IDX_W  = 4;
	localparam int unsigned KIND_W = 4;
	localparam int unsigned NREGS  = 31;
	localparam int unsigned PHYS_W = $clog2(NREGS);
	localparam int unsigned NSPSR  = 5;
	localparam int unsigned SLOT_W = $clog2(NSPSR);

	// access codes
	localparam logic [KIND_W-1:0] KIND_RD_MODE = 4'd0;
	localparam logic [KIND_W-1:0] KIND_WR_MODE = 4'd1;
	localparam logic [KIND_W-1:0] KIND_RD_USER = 4'd2;
	localparam logic [KIND_W-1:0] KIND_WR_USER = 4'd3;
	localparam logic [KIND_W-1:0] KIND_RD_CPSR = 4'd4;
	localparam logic [KIND_W-1:0] KIND_WR_CPSR = 4'd5;
	localparam logic [KIND_W-1:0] KIND_RD_SPSR = 4'd6;
	localparam logic [KIND_W-1:0] KIND_WR_SPSR = 4'd7;
	localparam logic [KIND_W-1:0] KIND_STATUS  = 4'd8;

	// processor modes
	localparam logic [MODE_W-1:0] MODE_USR = 5'h10;
	localparam logic [MODE_W-1:0] MODE_FIQ = 5'h11;
	localparam logic [MODE_W-1:0] MODE_IRQ = 5'h12;
	localparam logic [MODE_W-1:0] MODE_SVC = 5'h13;
	localparam logic [MODE_W-1:0] MODE_ABT = 5'h17;
	localparam logic [MODE_W-1:0] MODE_UND = 5'h1B;
	localparam logic [MODE_W-1:0] MODE_SYS = 5'h1F;

	// banked register boundaries
	localparam logic [IDX_W-1:0]  FIQ_FIRST  = 4'd8;
	localparam logic [IDX_W-1:0]  SP_INDEX   = 4'd13;
	localparam logic [IDX_W-1:0]  PC_INDEX   = 4'd15;
	localparam logic [PHYS_W-1:0] FIQ_BASE   = 5'd16;
	localparam logic [PHYS_W-1:0] OTHER_BASE = 5'd23;

	typedef enum logic {
		ST_IDLE,
		ST_BUSY
	} abrf_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic exec;
	} abrf_cmd_t;

	// decoded view of one mode
	typedef struct packed {
		logic              has_spsr;
		logic [SLOT_W-1:0] slot;
		logic              defined;
	} abrf_mode_t;

	function automatic abrf_mode_t decode_mode(input logic [MODE_W-1:0] mode);
		abrf_mode_t d;
		d.has_spsr = 1'b1;
		d.slot     = '0;
		d.defined  = 1'b1;
		case (mode)
			MODE_FIQ: d.slot = SLOT_W'(0);
			MODE_IRQ: d.slot = SLOT_W'(1);
			MODE_SVC: d.slot = SLOT_W'(2);
			MODE_ABT: d.slot = SLOT_W'(3);
			MODE_UND: d.slot = SLOT_W'(4);
			MODE_USR, MODE_SYS: d.has_spsr = 1'b0;
			default: begin
				d.has_spsr = 1'b0;
				d.defined  = 1'b0;
			end
		endcase
		return d;
	endfunction

	// physical entry of r0-r15 as seen through a mode's bank
	function automatic logic [PHYS_W-1:0] phys_index(input abrf_mode_t d,
		input logic [IDX_W-1:0] idx);
		logic [PHYS_W-1:0] p;
		p = PHYS_W'(idx);
		if (d.has_spsr && d.slot == '0) begin
			if (idx >= FIQ_FIRST && idx < PC_INDEX)
				p = FIQ_BASE + PHYS_W'(idx - FIQ_FIRST);
		end else if (d.has_spsr) begin
			if (idx >= SP_INDEX && idx < PC_INDEX)
				p = OTHER_BASE + PHYS_W'({d.slot - SLOT_W'(1), 1'b0})
					+ PHYS_W'(idx - SP_INDEX);
		end
		return p;
	endfunction

endpackage

### src/arm_banked_register_file_core.sv
// ARMv5 banked register file: top level joining controller and datapath
// One request is taken while the block is idle and executed once the result
// register is free or being emptied; no new request is taken until then, set
// by the capture/execute sequence of the controller. A new
// request is accepted while an earlier result still waits on out_stall; it
// executes as soon as that result is taken. All 31 general registers, the CPSR
// and the five SPSRs reset to zero, so the block starts in an undefined mode
// that uses the user bank. Status fields describe the mode before the access.
module arm_banked_register_file_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [abrf_pkg::KIND_W-1:0]    kind,
	input  logic [abrf_pkg::IDX_W-1:0]     reg_index,
	input  logic [abrf_pkg::DATA_W-1:0]    write_value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [abrf_pkg::DATA_W-1:0]    read_data,
	output logic [abrf_pkg::MODE_W-1:0]    cur_mode,
	output logic                           has_saved_status,
	output logic                           privileged,
	output logic                           bad_mode,
	output logic                           spsr_fault
);
	import abrf_pkg::*;

	abrf_cmd_t cmd;

	// sequencing
	abrf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// storage and access logic
	abrf_dpath u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.kind             (kind),
		.reg_index        (reg_index),
		.write_value      (write_value),
		.read_data        (read_data),
		.cur_mode         (cur_mode),
		.has_saved_status (has_saved_status),
		.privileged       (privileged),
		.bad_mode         (bad_mode),
		.spsr_fault       (spsr_fault)
	);

`ifndef NO_ASSERTIONS
	// an accepted request blocks the input until it has executed
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while a request is pending");

	// a new result only follows a pending request
	a_result_from_request: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a pending request");

	// a faulting saved status access never returns data
	a_fault_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && spsr_fault |-> read_data == '0 && !has_saved_status)
		else $error("saved status fault with data or saved status present");

	// an undefined mode has no saved status and counts as privileged
	a_bad_mode_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_mode |-> !has_saved_status && privileged)
		else $error("inconsistent flags for undefined mode");
`endif

endmodule

### src/abrf_ctrl.sv
// request sequencing: accept, execute, hold result until taken
module abrf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output abrf_pkg::abrf_cmd_t cmd
);
	import abrf_pkg::*;

	abrf_state_t state_q, state_d;
	logic        out_valid_q;

	// state and result flag registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// next state and commands
	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		in_stall    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
				if (in_valid)
					state_d = ST_BUSY;
			end
			ST_BUSY: begin
				// run once the result slot is free or being emptied
				if (!out_valid_q || !out_stall) begin
					cmd.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

### src/abrf_dpath.sv
// register storage, access decode and result register
module abrf_dpath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  abrf_pkg::abrf_cmd_t            cmd,
	input  logic [abrf_pkg::KIND_W-1:0]    kind,
	input  logic [abrf_pkg::IDX_W-1:0]     reg_index,
	input  logic [abrf_pkg::DATA_W-1:0]    write_value,
	output logic [abrf_pkg::DATA_W-1:0]    read_data,
	output logic [abrf_pkg::MODE_W-1:0]    cur_mode,
	output logic                           has_saved_status,
	output logic                           privileged,
	output logic                           bad_mode,
	output logic                           spsr_fault
);
	import abrf_pkg::*;

	logic [KIND_W-1:0] kind_q;
	logic [IDX_W-1:0]  idx_q;
	logic [DATA_W-1:0] value_q;

	logic [DATA_W-1:0] gregs_q [NREGS];
	logic [DATA_W-1:0] cpsr_q;
	logic [DATA_W-1:0] spsr_q  [NSPSR];

	logic [MODE_W-1:0] mode;
	abrf_mode_t        md;
	logic [PHYS_W-1:0] bank_idx;
	logic [PHYS_W-1:0] user_idx;
	logic [DATA_W-1:0] rdata;
	logic              fault;

	// captured request
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= kind;
			idx_q   <= reg_index;
			value_q <= write_value;
		end
	end

	// decode of the current mode and register address
	assign mode     = cpsr_q[MODE_W-1:0];
	assign md       = decode_mode(mode);
	assign bank_idx = phys_index(md, idx_q);
	assign user_idx = PHYS_W'(idx_q);

	// read selection
	always_comb begin
		rdata = '0;
		fault = 1'b0;
		case (kind_q)
			KIND_RD_MODE: rdata = gregs_q[bank_idx];
			KIND_RD_USER: rdata = gregs_q[user_idx];
			KIND_RD_CPSR: rdata = cpsr_q;
			KIND_RD_SPSR: begin
				if (md.has_spsr)
					rdata = spsr_q[md.slot];
				else
					fault = 1'b1;
			end
			KIND_WR_SPSR: fault = !md.has_spsr;
			default: rdata = '0;
		endcase
	end

	// architectural state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NREGS; i++)
				gregs_q[i] <= '0;
			for (int i = 0; i < NSPSR; i++)
				spsr_q[i] <= '0;
			cpsr_q <= '0;
		end else if (cmd.exec) begin
			case (kind_q)
				KIND_WR_MODE: gregs_q[bank_idx] <= value_q;
				KIND_WR_USER: gregs_q[user_idx] <= value_q;
				KIND_WR_CPSR: cpsr_q <= value_q;
				KIND_WR_SPSR: begin
					if (md.has_spsr)
						spsr_q[md.slot] <= value_q;
				end
				default: ;
			endcase
		end
	end

	// result register, status taken from the mode before this access
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			read_data        <= rdata;
			cur_mode         <= mode;
			has_saved_status <= md.has_spsr;
			privileged       <= (mode != MODE_USR);
			bad_mode         <= !md.defined;
			spsr_fault       <= fault;
		end
	end

endmodule

### dv/abrf_access_checker.sv
// checker for the banked register file: shadow state, expected results and comparison
`timescale 1ns / 1ps

module abrf_access_checker
	import abrf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [KIND_W-1:0] kind,
	input  logic [IDX_W-1:0]  reg_index,
	input  logic [DATA_W-1:0] write_value,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [DATA_W-1:0] read_data,
	input  logic [MODE_W-1:0] cur_mode,
	input  logic              has_saved_status,
	input  logic              privileged,
	input  logic              bad_mode,
	input  logic              spsr_fault,
	output int                fail_count,
	output int                pending,
	output int                results_seen,
	output int                faults_seen,
	output int                undefined_seen
);

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic [MODE_W-1:0] mode;
		logic              has_ss;
		logic              priv;
		logic              bad;
		logic              fault;
	} access_outcome_t;

	// shadow copy of the register file
	logic [DATA_W-1:0] gpr_shadow [NREGS];
	logic [DATA_W-1:0] cpsr_shadow;
	logic [DATA_W-1:0] spsr_shadow [NSPSR];

	access_outcome_t pending_outcomes [$];
	int mismatches;
	int results_total;
	int faults_total;
	int undefined_total;

	// spsr slot of a mode, -1 where the mode has none
	function automatic int spsr_bank(input logic [MODE_W-1:0] m);
		case (m)
			MODE_FIQ: return 0;
			MODE_IRQ: return 1;
			MODE_SVC: return 2;
			MODE_ABT: return 3;
			MODE_UND: return 4;
			default:  return -1;
		endcase
	endfunction

	// fiq shadows r8-r14, the other exception modes only sp and lr
	function automatic int bank_entry(input logic [MODE_W-1:0] m, input logic [IDX_W-1:0] r);
		int b;
		b = spsr_bank(m);
		if (b == 0 && r >= FIQ_FIRST && r < PC_INDEX)
			return int'(FIQ_BASE) + int'(r - FIQ_FIRST);
		if (b > 0 && r >= SP_INDEX && r < PC_INDEX)
			return int'(OTHER_BASE) + 2 * (b - 1) + int'(r - SP_INDEX);
		return int'(r);
	endfunction

	// apply one request to the shadow state; status reflects the mode before it
	function automatic access_outcome_t perform_access(input logic [KIND_W-1:0] k,
		input logic [IDX_W-1:0] r, input logic [DATA_W-1:0] v);
		access_outcome_t o;
		logic [MODE_W-1:0] m;
		int b;
		m = cpsr_shadow[MODE_W-1:0];
		b = spsr_bank(m);
		o = '0;
		o.mode   = m;
		o.has_ss = (b >= 0);
		o.priv   = (m != MODE_USR);
		o.bad    = (b < 0) && (m != MODE_USR) && (m != MODE_SYS);
		case (k)
			KIND_RD_MODE: o.read_data = gpr_shadow[bank_entry(m, r)];
			KIND_WR_MODE: gpr_shadow[bank_entry(m, r)] = v;
			KIND_RD_USER: o.read_data = gpr_shadow[r];
			KIND_WR_USER: gpr_shadow[r] = v;
			KIND_RD_CPSR: o.read_data = cpsr_shadow;
			KIND_WR_CPSR: cpsr_shadow = v;
			KIND_RD_SPSR: begin
				if (b >= 0)
					o.read_data = spsr_shadow[b];
				else
					o.fault = 1'b1;
			end
			KIND_WR_SPSR: begin
				if (b >= 0)
					spsr_shadow[b] = v;
				else
					o.fault = 1'b1;
			end
			default: ;
		endcase
		return o;
	endfunction

	// watch both channels, compare results, then predict new requests
	always @(posedge clk or negedge arst_n) begin
		access_outcome_t want;
		access_outcome_t got;
		if (!arst_n) begin
			foreach (gpr_shadow[i]) gpr_shadow[i] = '0;
			foreach (spsr_shadow[i]) spsr_shadow[i] = '0;
			cpsr_shadow = '0;
			pending_outcomes.delete();
			mismatches = 0;
			results_total = 0;
			faults_total = 0;
			undefined_total = 0;
			fail_count <= 0;
			pending <= 0;
			results_seen <= 0;
			faults_seen <= 0;
			undefined_seen <= 0;
		end else begin
			// a result always belongs to an earlier request, so take it first
			if (out_valid && !out_stall) begin
				got = {read_data, cur_mode, has_saved_status, privileged, bad_mode, spsr_fault};
				results_total++;
				if (got.fault)
					faults_total++;
				if (got.bad)
					undefined_total++;
				if (pending_outcomes.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %0d: data=%h mode=%h ss=%b priv=%b bad=%b fault=%b",
							results_total, got.read_data, got.mode, got.has_ss, got.priv,
							got.bad, got.fault);
				end else begin
					want = pending_outcomes.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch on result %0d", results_total);
							$display("  expected data=%h mode=%h ss=%b priv=%b bad=%b fault=%b",
								want.read_data, want.mode, want.has_ss, want.priv,
								want.bad, want.fault);
							$display("  actual   data=%h mode=%h ss=%b priv=%b bad=%b fault=%b",
								got.read_data, got.mode, got.has_ss, got.priv,
								got.bad, got.fault);
						end
					end
				end
			end
			if (in_valid && !in_stall)
				pending_outcomes.push_back(perform_access(kind, reg_index, write_value));
			fail_count <= mismatches;
			pending <= pending_outcomes.size();
			results_seen <= results_total;
			faults_seen <= faults_total;
			undefined_seen <= undefined_total;
		end
	end

endmodule

### dv/tb_arm_banked_register_file_core.sv
// testbench top for the banked register file: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps

module tb_arm_banked_register_file_core;
	import abrf_pkg::*;

	localparam int RANDOM_ITEMS = 1650;
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 10;

	// kinds the block ignores
	localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = KIND_STATUS + 4'd1;
	localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 4'hF;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_LIGHT,
		RX_PERIODIC,
		RX_HEAVY
	} rx_style_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              out_stall = 1'b0;
	logic [KIND_W-1:0] kind = '0;
	logic [IDX_W-1:0]  reg_index = '0;
	logic [DATA_W-1:0] write_value = '0;
	logic              in_stall;
	logic              out_valid;
	logic [DATA_W-1:0] read_data;
	logic [MODE_W-1:0] cur_mode;
	logic              has_saved_status;
	logic              privileged;
	logic              bad_mode;
	logic              spsr_fault;

	int fail_count;
	int pending;
	int results_seen;
	int faults_seen;
	int undefined_seen;

	int        requests_sent = 0;
	int        spare_sent = 0;
	int        burst_left = 0;
	bit        steady_send = 1'b0;
	int        quiet_cycles = 0;
	int        stall_tick = 0;
	rx_style_t stall_style = RX_OPEN;

	logic [MODE_W-1:0] known_modes [7] = '{MODE_USR, MODE_FIQ, MODE_IRQ, MODE_SVC,
		MODE_ABT, MODE_UND, MODE_SYS};

	always #5 clk = ~clk;

	arm_banked_register_file_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.kind             (kind),
		.reg_index        (reg_index),
		.write_value      (write_value),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.read_data        (read_data),
		.cur_mode         (cur_mode),
		.has_saved_status (has_saved_status),
		.privileged       (privileged),
		.bad_mode         (bad_mode),
		.spsr_fault       (spsr_fault)
	);

	abrf_access_checker access_chk (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.kind             (kind),
		.reg_index        (reg_index),
		.write_value      (write_value),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.read_data        (read_data),
		.cur_mode         (cur_mode),
		.has_saved_status (has_saved_status),
		.privileged       (privileged),
		.bad_mode         (bad_mode),
		.spsr_fault       (spsr_fault),
		.fail_count       (fail_count),
		.pending          (pending),
		.results_seen     (results_seen),
		.faults_seen      (faults_seen),
		.undefined_seen   (undefined_seen)
	);

	// result side stalls in a style that is periodically redrawn at random
	always @(posedge clk) begin
		stall_tick <= stall_tick + 1;
		if (stall_tick % 160 == 0)
			stall_style <= rx_style_t'($urandom_range(0, 3));
		case (stall_style)
			RX_OPEN:     out_stall <= 1'b0;
			RX_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
			RX_PERIODIC: out_stall <= ((stall_tick % 7) < 3);
			default:     out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// watchdog on cycles with no traffic on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("no traffic for %0d cycles, %0d results outstanding", quiet_cycles, pending);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// present one request, with a gap first when a burst has run out
	task automatic send_req(input logic [KIND_W-1:0] k, input logic [IDX_W-1:0] r,
		input logic [DATA_W-1:0] v);
		int gap;
		gap = 0;
		if (!steady_send) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 6);
				burst_left = $urandom_range(1, 16);
			end else begin
				burst_left--;
			end
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		reg_index <= r;
		write_value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		requests_sent++;
		if (k >= KIND_SPARE_FIRST)
			spare_sent++;
	endtask

	// data with the extremes weighted in
	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return 32'h8000_0000;
			default: return $urandom();
		endcase
	endfunction

	// cpsr values mostly select a defined mode, sometimes any mode field
	function automatic logic [DATA_W-1:0] pick_cpsr();
		logic [DATA_W-1:0] v;
		v = pick_value();
		if ($urandom_range(0, 9) != 0)
			v[MODE_W-1:0] = known_modes[$urandom_range(0, 6)];
		return v;
	endfunction

	function automatic logic [KIND_W-1:0] pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 28)
			return KIND_RD_MODE;
		else if (r < 52)
			return KIND_WR_MODE;
		else if (r < 60)
			return KIND_RD_USER;
		else if (r < 67)
			return KIND_WR_USER;
		else if (r < 71)
			return KIND_RD_CPSR;
		else if (r < 80)
			return KIND_WR_CPSR;
		else if (r < 87)
			return KIND_RD_SPSR;
		else if (r < 94)
			return KIND_WR_SPSR;
		else if (r < 97)
			return KIND_STATUS;
		return KIND_W'($urandom_range(int'(KIND_SPARE_FIRST), int'(KIND_SPARE_LAST)));
	endfunction

	initial begin
		logic [KIND_W-1:0] k;
		logic [DATA_W-1:0] v;
		int useful;

		// reset
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// out of reset the mode field is zero, an undefined mode on the user bank
		send_req(KIND_STATUS, '0, '0);
		send_req(KIND_RD_SPSR, '0, '0);
		send_req(KIND_WR_SPSR, '0, '1);
		send_req(KIND_WR_MODE, PC_INDEX, '1);
		send_req(KIND_RD_USER, PC_INDEX, '0);
		send_req(KIND_SPARE_LAST, 4'hF, '1);
		// mode change: status still shows the old mode on the cpsr write itself
		send_req(KIND_WR_CPSR, '0, {27'h7FF_FFFF, MODE_FIQ});
		send_req(KIND_WR_MODE, FIQ_FIRST, 32'hA5A5_5A5A);
		send_req(KIND_WR_MODE, 4'd14, 32'h1234_5678);
		send_req(KIND_RD_USER, FIQ_FIRST, '0);
		send_req(KIND_WR_SPSR, '0, '1);
		send_req(KIND_RD_SPSR, '0, '0);
		send_req(KIND_WR_CPSR, '0, {27'd0, MODE_IRQ});
		send_req(KIND_RD_MODE, FIQ_FIRST, '0);
		send_req(KIND_WR_MODE, SP_INDEX, 32'h8000_0001);
		send_req(KIND_RD_SPSR, '0, '0);
		// user and system have no spsr
		send_req(KIND_WR_CPSR, '0, {27'd0, MODE_USR});
		send_req(KIND_RD_SPSR, '0, '0);
		send_req(KIND_RD_MODE, SP_INDEX, '0);
		send_req(KIND_WR_CPSR, '0, {27'h7FF_FFFF, MODE_SYS});
		send_req(KIND_WR_SPSR, '0, '0);
		send_req(KIND_RD_CPSR, '0, '0);
		send_req(KIND_WR_CPSR, '0, {27'd0, MODE_UND});
		send_req(KIND_RD_MODE, 4'd14, '0);
		// a mode field between defined modes
		send_req(KIND_WR_CPSR, '0, {27'd0, 5'h15});

		// random requests, idling style changes now and then
		useful = 0;
		while (useful < RANDOM_ITEMS) begin
			if (useful % 150 == 0)
				steady_send = ($urandom_range(0, 3) == 0);
			k = pick_kind();
			v = (k == KIND_WR_CPSR) ? pick_cpsr() : pick_value();
			send_req(k, IDX_W'($urandom_range(0, 15)), v);
			if (k < KIND_SPARE_FIRST)
				useful++;
		end
		in_valid <= 1'b0;

		// drain
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d requests (%0d of ignored kinds), checked %0d results",
			requests_sent, spare_sent, results_seen);
		$display("%0d results carried an spsr fault, %0d came from undefined modes",
			faults_seen, undefined_seen);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
